FILE: rtl/lrtr_pkg.sv
// shared constants, types and helper functions of the tapered runner renderer
package lrtr_pkg;

    localparam int RING_PIXELS  = 24;
    localparam int MAX_SEGMENTS = 5;

    localparam int SPAN      = RING_PIXELS * 256;
    localparam int POS_W     = $clog2(SPAN);
    localparam int PIX_W     = $clog2(RING_PIXELS);
    localparam int LEN_W     = $clog2(RING_PIXELS + 2);
    localparam int SEG_W     = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int SPEED_LIM = SPAN - 1;

    // percent * RING_PIXELS / 100 as a multiply by reciprocal
    localparam int LEN_SHIFT = 19;
    localparam int LEN_MULT  = RING_PIXELS * 5243;

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam logic [2:0] REG_SEGMENT_COUNT = 3'd0;
    localparam logic [2:0] REG_SEGMENT_BASE  = 3'd1;
    localparam logic [2:0] RESET_COUNT       = 3'd3;

    typedef struct packed {
        logic [6:0]  pct;
        logic [15:0] speed;
        logic [23:0] color;
    } t_seg_cfg;

    // effective number of drawn segments
    function automatic logic [3:0] active_count(input logic [2:0] cnt);
        logic [3:0] c;
        c = {1'b0, cnt};
        if (c == 4'd0) c = 4'd1;
        if (c > 4'(MAX_SEGMENTS)) c = 4'(MAX_SEGMENTS);
        return c;
    endfunction

    // evenly spaced start position of segment idx for a given count
    function automatic logic [POS_W-1:0] respace_pos(input logic [3:0] cnt,
                                                     input logic [3:0] idx);
        logic [POS_W:0]   offset;
        logic [POS_W+4:0] prod;
        case (cnt)
            4'd1:    offset = (POS_W+1)'(SPAN / 1);
            4'd2:    offset = (POS_W+1)'(SPAN / 2);
            4'd3:    offset = (POS_W+1)'(SPAN / 3);
            4'd4:    offset = (POS_W+1)'(SPAN / 4);
            default: offset = (POS_W+1)'(SPAN / 5);
        endcase
        prod = offset * idx;
        return (idx < cnt) ? prod[POS_W-1:0] : '0;
    endfunction

endpackage

FILE: rtl/lrtr_regs.sv
// apb register file holding segment count and per-segment settings
module lrtr_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lrtr_pkg::ADDR_W-1:0]          paddr,
    input  logic [lrtr_pkg::DATA_W-1:0]          pwdata,
    output logic [lrtr_pkg::DATA_W-1:0]          prdata,
    output logic [2:0]                           o_count,
    output lrtr_pkg::t_seg_cfg                   o_seg [lrtr_pkg::MAX_SEGMENTS]
);

    logic [2:0]         r_count;
    lrtr_pkg::t_seg_cfg r_seg [lrtr_pkg::MAX_SEGMENTS];
    logic [2:0]         idx;
    logic               wr;

    assign idx = paddr[5:3];
    assign wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= lrtr_pkg::RESET_COUNT;
            for (int s = 0; s < lrtr_pkg::MAX_SEGMENTS; s++) begin
                r_seg[s] <= '0;
            end
        end else if (wr) begin
            if (idx == lrtr_pkg::REG_SEGMENT_COUNT) begin
                r_count <= pwdata[2:0];
            end
            for (int s = 0; s < lrtr_pkg::MAX_SEGMENTS; s++) begin
                if (idx == lrtr_pkg::REG_SEGMENT_BASE + 3'(s)) begin
                    r_seg[s] <= pwdata[46:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (idx == lrtr_pkg::REG_SEGMENT_COUNT) begin
            prdata = {61'd0, r_count};
        end
        for (int s = 0; s < lrtr_pkg::MAX_SEGMENTS; s++) begin
            if (idx == lrtr_pkg::REG_SEGMENT_BASE + 3'(s)) begin
                prdata = {17'd0, r_seg[s]};
            end
        end
    end

    assign o_count = r_count;
    assign o_seg   = r_seg;

endmodule

FILE: rtl/lrtr_div.sv
// three-lane restoring divider, one quotient bit per cycle
module lrtr_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lrtr_pkg::LEN_W-1:0] i_divisor,
    input  logic [7:0]                 i_dividend [3],
    output logic                       o_done,
    output logic [7:0]                 o_quot [3]
);

    logic                       r_busy;
    logic                       r_done;
    logic [2:0]                 r_cnt;
    logic [lrtr_pkg::LEN_W-1:0] r_div;
    logic [lrtr_pkg::LEN_W-1:0] r_rem [3];
    logic [7:0]                 r_q [3];
    logic [lrtr_pkg::LEN_W:0]   sh [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sh[c] = {r_rem[c], r_q[c][7]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 3'd7);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            for (int c = 0; c < 3; c++) begin
                r_rem[c] <= '0;
                r_q[c]   <= i_dividend[c];
            end
        end else if (r_busy) begin
            for (int c = 0; c < 3; c++) begin
                if (sh[c] >= {1'b0, r_div}) begin
                    r_rem[c] <= lrtr_pkg::LEN_W'(sh[c] - {1'b0, r_div});
                    r_q[c]   <= {r_q[c][6:0], 1'b1};
                end else begin
                    r_rem[c] <= sh[c][lrtr_pkg::LEN_W-1:0];
                    r_q[c]   <= {r_q[c][6:0], 1'b0};
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: rtl/lrtr_frame_mem.sv
// frame store memory with per-pixel valid bits, so a clear resets all valid bits together
module lrtr_frame_mem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic                       i_we,
    input  logic [lrtr_pkg::PIX_W-1:0] i_waddr,
    input  logic [23:0]                i_wdata,
    input  logic                       i_re,
    input  logic [lrtr_pkg::PIX_W-1:0] i_raddr,
    output logic [23:0]                o_rdata
);

    logic [23:0]                       r_mem [lrtr_pkg::RING_PIXELS];
    logic [lrtr_pkg::RING_PIXELS-1:0]  r_valid;
    logic [23:0]                       r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : 24'd0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/led_ring_tapered_runner_renderer.sv
// top level: tapered runner renderer for a ring of rgb pixels
// per frame: for each active segment a load, a divider run and a read-modify-write
//   of each of its len+1 taper slots, then the 24 pixels are read out and offered in turn
// throughput: one frame at a time, next frame request taken once the last pixel is taken
// the read-modify-write of the frame store and the taper divider set the rate
// reset (synchronous, active low): 3 segments evenly spaced, settings zero, frame clear
module led_ring_tapered_runner_renderer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_restart,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [4:0]                    o_pixel_index,
    output logic [7:0]                    o_red,
    output logic [7:0]                    o_green,
    output logic [7:0]                    o_blue,
    output logic                          o_last_pixel,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lrtr_pkg::ADDR_W-1:0]   paddr,
    input  logic [lrtr_pkg::DATA_W-1:0]   pwdata,
    output logic [lrtr_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int POS_W = lrtr_pkg::POS_W;
    localparam int PIX_W = lrtr_pkg::PIX_W;
    localparam int LEN_W = lrtr_pkg::LEN_W;
    localparam int SEG_W = lrtr_pkg::SEG_W;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_LOAD     = 9'b000000010,
        S_DSTART   = 9'b000000100,
        S_DWAIT    = 9'b000001000,
        S_TAP      = 9'b000010000,
        S_BLEND    = 9'b000100000,
        S_WRITE    = 9'b001000000,
        S_EMIT_RD  = 9'b010000000,
        S_EMIT_OUT = 9'b100000000
    } t_state;

    // register file
    logic [2:0]         cfg_count;
    lrtr_pkg::t_seg_cfg cfg_seg [lrtr_pkg::MAX_SEGMENTS];

    lrtr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_count (cfg_count),
        .o_seg   (cfg_seg)
    );

    assign pready = 1'b1;

    // control and datapath registers
    t_state                r_state, n_state;
    logic [SEG_W-1:0]      r_seg;
    logic [POS_W-1:0]      r_pos [lrtr_pkg::MAX_SEGMENTS];
    logic [LEN_W-1:0]      r_len;
    logic [LEN_W-1:0]      r_i;
    logic [PIX_W-1:0]      r_px;
    logic [PIX_W-1:0]      r_k;
    logic [7:0]            r_frac;
    logic [23:0]           r_color;
    logic [7:0]            r_v1 [3];
    logic [7:0]            r_v2 [3];
    logic [7:0]            r_bl [3];

    logic [3:0]            act_cnt;
    lrtr_pkg::t_seg_cfg    cur;
    logic signed [16:0]    spd;
    logic signed [16:0]    np;
    logic [POS_W-1:0]      np_w;
    logic [6:0]            pct_c;
    logic [31:0]           len_prod;
    logic [LEN_W-1:0]      len_raw;
    logic [LEN_W-1:0]      len_c;
    logic                  in_xfer;
    logic                  out_xfer;
    logic                  div_done;
    logic [7:0]            div_quot [3];
    logic [7:0]            div_in [3];
    logic [23:0]           rdata;
    logic [23:0]           wdata;
    logic [PIX_W-1:0]      px_next;

    assign act_cnt  = lrtr_pkg::active_count(cfg_count);
    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = o_valid && i_ready;

    // taper slot value of one channel; slot 0 and slot len+1 are dark
    function automatic logic [7:0] taper(input logic [LEN_W-1:0] len,
                                         input logic [LEN_W-1:0] slot,
                                         input logic [7:0] step);
        logic [LEN_W-1:0]   mid;
        logic [LEN_W-1:0]   idx;
        logic [LEN_W+7:0]   prod;
        mid  = len >> 1;
        idx  = (slot <= mid) ? slot + LEN_W'(1) : len - slot;
        prod = step * idx;
        if (slot == '0 || {1'b0, slot} == {1'b0, len} + (LEN_W+1)'(1)) begin
            return 8'd0;
        end
        return prod[7:0];
    endfunction

    // advance the current segment with clamped speed and a single wrap
    always_comb begin
        cur = cfg_seg[r_seg];
        spd = 17'(signed'(cur.speed));
        if (spd > 17'(lrtr_pkg::SPEED_LIM)) spd = 17'(lrtr_pkg::SPEED_LIM);
        if (spd < -17'(lrtr_pkg::SPEED_LIM)) spd = -17'(lrtr_pkg::SPEED_LIM);
        np = signed'({{(17-POS_W){1'b0}}, r_pos[r_seg]}) + spd;
        if (np >= 17'(lrtr_pkg::SPAN)) begin
            np = np - 17'(lrtr_pkg::SPAN);
        end else if (np < 17'sd0) begin
            np = np + 17'(lrtr_pkg::SPAN);
        end
        np_w = np[POS_W-1:0];
        // taper length in pixels, at least two
        pct_c    = (cur.pct > 7'd100) ? 7'd100 : cur.pct;
        len_prod = 32'(pct_c) * 32'(lrtr_pkg::LEN_MULT);
        len_raw  = LEN_W'(len_prod >> lrtr_pkg::LEN_SHIFT);
        len_c    = (len_raw < LEN_W'(2)) ? LEN_W'(2) : len_raw;
    end

    // per-channel step = channel / (len/2 + 1)
    assign div_in[0] = r_color[23:16];
    assign div_in[1] = r_color[15:8];
    assign div_in[2] = r_color[7:0];

    lrtr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DSTART),
        .i_divisor  ((r_len >> 1) + LEN_W'(1)),
        .i_dividend (div_in),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // saturating add of the blended taper into the stored pixel
    always_comb begin
        logic [8:0] s;
        wdata = '0;
        for (int c = 0; c < 3; c++) begin
            s = {1'b0, rdata[23-8*c -: 8]} + {1'b0, r_bl[c]};
            wdata[23-8*c -: 8] = s[8] ? 8'hff : s[7:0];
        end
    end

    assign px_next = (r_px == PIX_W'(lrtr_pkg::RING_PIXELS - 1)) ? '0 : r_px + PIX_W'(1);

    lrtr_frame_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (in_xfer),
        .i_we    (r_state == S_WRITE),
        .i_waddr (r_px),
        .i_wdata (wdata),
        .i_re    ((r_state == S_TAP) || (r_state == S_EMIT_RD)),
        .i_raddr ((r_state == S_TAP) ? r_px : r_k),
        .o_rdata (rdata)
    );

    // frame sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_valid) n_state = S_LOAD;
            S_LOAD:     n_state = S_DSTART;
            S_DSTART:   n_state = S_DWAIT;
            S_DWAIT:    if (div_done) n_state = S_TAP;
            S_TAP:      n_state = S_BLEND;
            S_BLEND:    n_state = S_WRITE;
            S_WRITE: begin
                if (r_i != r_len) begin
                    n_state = S_TAP;
                end else if ({1'b0, r_seg} + (SEG_W+1)'(1) == (SEG_W+1)'(act_cnt)) begin
                    n_state = S_EMIT_RD;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_EMIT_RD:  n_state = S_EMIT_OUT;
            S_EMIT_OUT: begin
                if (i_ready) begin
                    n_state = (r_k == PIX_W'(lrtr_pkg::RING_PIXELS - 1)) ? S_IDLE : S_EMIT_RD;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seg   <= '0;
            r_k     <= '0;
            for (int s = 0; s < lrtr_pkg::MAX_SEGMENTS; s++) begin
                r_pos[s] <= lrtr_pkg::respace_pos(
                    lrtr_pkg::active_count(lrtr_pkg::RESET_COUNT), 4'(s));
            end
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_seg <= '0;
                r_k   <= '0;
                // restart respaces every segment before this frame moves them
                if (i_restart) begin
                    for (int s = 0; s < lrtr_pkg::MAX_SEGMENTS; s++) begin
                        r_pos[s] <= lrtr_pkg::respace_pos(act_cnt, 4'(s));
                    end
                end
            end
            if (r_state == S_LOAD) begin
                r_pos[r_seg] <= np_w;
            end
            if (r_state == S_WRITE && r_i == r_len) begin
                r_seg <= r_seg + SEG_W'(1);
            end
            if (out_xfer) begin
                r_k <= r_k + PIX_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        logic [16:0] acc;
        if (r_state == S_LOAD) begin
            r_len   <= len_c;
            r_color <= cur.color;
            r_frac  <= np_w[7:0];
            r_px    <= np_w[POS_W-1:8];
            r_i     <= '0;
        end
        if (r_state == S_TAP) begin
            for (int c = 0; c < 3; c++) begin
                r_v1[c] <= taper(r_len, r_i, div_quot[c]);
                r_v2[c] <= taper(r_len, r_i + LEN_W'(1), div_quot[c]);
            end
        end
        if (r_state == S_BLEND) begin
            // weight of the lower slot is frac+1, of the upper 255-frac
            for (int c = 0; c < 3; c++) begin
                acc = 17'(r_v1[c]) * 17'({1'b0, r_frac} + 9'd1)
                    + 17'(r_v2[c]) * 17'(8'd255 - r_frac);
                r_bl[c] <= acc[15:8];
            end
        end
        if (r_state == S_WRITE) begin
            r_i  <= r_i + LEN_W'(1);
            r_px <= px_next;
        end
    end

    // ports
    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_EMIT_OUT);
    assign o_pixel_index = 5'(r_k);
    assign o_red         = rdata[23:16];
    assign o_green       = rdata[15:8];
    assign o_blue        = rdata[7:0];
    assign o_last_pixel  = (r_k == PIX_W'(lrtr_pkg::RING_PIXELS - 1));

endmodule

FILE: rtl/lrtr_checker.sv
// port-level checker for the renderer, bound to the top level
module lrtr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [4:0] o_pixel_index,
    input logic       o_last_pixel
);

    // a stalled pixel holds its index
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_index))
        else $error("pixel index changed while stalled");

    // no pixel is offered while waiting for a frame request
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("pixel offered while idle");

    // a frame request starts rendering, not another request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken twice");

    // last flag only on the final ring pixel, then the block returns to idle
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last_pixel |=> o_ready && !o_valid)
        else $error("frame did not end after last pixel");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_pixel |-> o_pixel_index == 5'(lrtr_pkg::RING_PIXELS - 1))
        else $error("last flag on wrong pixel");

endmodule

bind led_ring_tapered_runner_renderer lrtr_checker u_lrtr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_pixel_index (o_pixel_index),
    .o_last_pixel  (o_last_pixel)
);
